>>> hdl/dpt_pkg.sv
// ----------------------------------------------------------------------------
// dpt_pkg: shared types and constants for the dual prescaled timer
// Holds the command and result payloads, register codes, control field
// positions and the per-timer control and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package dpt_pkg;

	// Operation codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// Register select codes
	localparam logic [2:0] REG_TIMER_SCALE = 3'd0;
	localparam logic [2:0] REG_COUNT_SCALE = 3'd1;
	localparam logic [2:0] REG_COUNTER     = 3'd2;
	localparam logic [2:0] REG_CONTROL     = 3'd3;
	localparam logic [2:0] REG_TIMER_VALUE = 3'd4;
	localparam logic [2:0] REG_TARGET      = 3'd5;

	// Control register fields
	localparam int CTRL_ENABLE_BIT = 1;
	localparam int SHIFT_LSB       = 4;
	localparam int SHIFT_WIDTH     = 3;

	// Result IRQ vector width
	localparam int IRQ_WIDTH = 2;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  reg_select;
		logic        index;
		logic [31:0] mask;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [31:0]          read_data;
		logic [IRQ_WIDTH-1:0] irq;
	} res_t;

	// Per-timer strobes and write data
	typedef struct packed {
		logic        tick;
		logic        wr_control;
		logic        wr_value;
		logic        wr_target;
		logic [31:0] mask;
		logic [31:0] value;
	} lane_ctl_t;

	// Per-timer read view and match flag
	typedef struct packed {
		logic [31:0] control;
		logic [31:0] view;
		logic        irq;
	} lane_stat_t;

	// Masked merge of write data into an old value
	function automatic logic [31:0] merge32(input logic [31:0] old_val,
		input logic [31:0] mask, input logic [31:0] new_val);
		return (old_val & ~mask) | (new_val & mask);
	endfunction

endpackage

`default_nettype wire

>>> hdl/dual_prescaled_timer_with_counter.sv
// ----------------------------------------------------------------------------
// dual_prescaled_timer_with_counter: prescaled timers and free counter
// Free-running 32-bit counter and NUM_TIMERS target-compare timers, each
// group behind its own prescaler, driven by tick, read and write commands.
//
//   channel | direction | handshake            | payload
//   cmd     | in        | cmd_valid, cmd_stall | dpt_pkg::cmd_t
//   res     | out       | res_valid, res_stall | dpt_pkg::res_t
//
// One command is accepted per cycle while cmd_stall is low; each gives one
// result via the command and result registers. The path between the two
// (64-bit timer compare and increment) sets the clock rate.
// Reset clears all timer, counter and prescaler state.
// cmd_stall rises only while the result register is full and stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_prescaled_timer_with_counter #(
	parameter int NUM_TIMERS = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output      logic          cmd_stall,
	input  wire dpt_pkg::cmd_t cmd,
	output      logic          res_valid,
	input  wire logic          res_stall,
	output      dpt_pkg::res_t res
);
	import dpt_pkg::*;

	localparam int IRQ_LANES = (NUM_TIMERS < IRQ_WIDTH) ? NUM_TIMERS : IRQ_WIDTH;

	cmd_t        cmd_s1;
	logic        valid_s1;
	res_t        res_s2;
	logic        valid_s2;
	logic        advance;
	logic        fire_s1;
	logic        tick_s1;
	logic        wr_s1;
	logic        tfire;
	logic        cfire;
	logic [31:0] counter_q;
	res_t        res_c;

	lane_ctl_t   lane_ctl  [NUM_TIMERS];
	lane_stat_t  lane_stat [NUM_TIMERS];

	// Move the command stage forward when the result register frees up
	assign advance   = !valid_s2 || !res_stall;
	assign fire_s1   = valid_s1 && advance;
	assign cmd_stall = valid_s1 && !advance;
	assign tick_s1   = fire_s1 && (cmd_s1.op == OP_TICK);
	assign wr_s1     = fire_s1 && (cmd_s1.op == OP_WRITE);

	// Capture the command transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	// Timer and counter prescalers
	dpt_prescaler u_timer_pre (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (tick_s1),
		.wr    (wr_s1 && (cmd_s1.reg_select == REG_TIMER_SCALE)),
		.mask  (cmd_s1.mask),
		.value (cmd_s1.value),
		.fire  (tfire)
	);

	dpt_prescaler u_count_pre (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (tick_s1),
		.wr    (wr_s1 && (cmd_s1.reg_select == REG_COUNT_SCALE)),
		.mask  (cmd_s1.mask),
		.value (cmd_s1.value),
		.fire  (cfire)
	);

	// Advance or write the free-running counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
		end else if (wr_s1 && (cmd_s1.reg_select == REG_COUNTER)) begin
			counter_q <= merge32(counter_q, cmd_s1.mask, cmd_s1.value);
		end else if (cfire) begin
			counter_q <= counter_q + 32'd1;
		end
	end

	// Timer lanes
	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_lane
		logic hit;
		assign hit = ({31'b0, cmd_s1.index} == 32'(i));

		always_comb begin
			lane_ctl[i].tick       = tfire;
			lane_ctl[i].wr_control = wr_s1 && hit && (cmd_s1.reg_select == REG_CONTROL);
			lane_ctl[i].wr_value   = wr_s1 && hit && (cmd_s1.reg_select == REG_TIMER_VALUE);
			lane_ctl[i].wr_target  = wr_s1 && hit && (cmd_s1.reg_select == REG_TARGET);
			lane_ctl[i].mask       = cmd_s1.mask;
			lane_ctl[i].value      = cmd_s1.value;
		end

		dpt_timer_lane u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (lane_ctl[i]),
			.stat  (lane_stat[i])
		);
	end

	// Build the result: read mux for reads, IRQ bits for ticks
	always_comb begin
		res_c = '0;
		if (cmd_s1.op == OP_TICK) begin
			for (int i = 0; i < IRQ_LANES; i++) begin
				res_c.irq[i] = lane_stat[i].irq;
			end
		end else if (cmd_s1.op == OP_READ) begin
			case (cmd_s1.reg_select)
				REG_COUNTER: begin
					res_c.read_data = counter_q;
				end
				REG_CONTROL: begin
					for (int i = 0; i < NUM_TIMERS; i++) begin
						if ({31'b0, cmd_s1.index} == 32'(i)) begin
							res_c.read_data = lane_stat[i].control;
						end
					end
				end
				REG_TIMER_VALUE: begin
					for (int i = 0; i < NUM_TIMERS; i++) begin
						if ({31'b0, cmd_s1.index} == 32'(i)) begin
							res_c.read_data = lane_stat[i].view;
						end
					end
				end
				default: begin
					res_c.read_data = '0;
				end
			endcase
		end
	end

	// Hold the result transaction until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_s2 <= res_c;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

endmodule

`default_nettype wire

>>> hdl/dpt_prescaler.sv
// ----------------------------------------------------------------------------
// dpt_prescaler: tick prescaler
// Fires on the tick that completes scale+1 ticks since the last fire or the
// last scale write; a scale of all ones spans 2^32 ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_prescaler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        tick,
	input  wire logic        wr,
	input  wire logic [31:0] mask,
	input  wire logic [31:0] value,
	output      logic        fire
);
	import dpt_pkg::*;

	logic [31:0] scale_q;
	logic [32:0] wait_q;
	logic [32:0] wait_inc;
	logic [32:0] period;

	// Advance the wait count and compare with scale plus one
	assign wait_inc = wait_q + 33'd1;
	assign period   = {1'b0, scale_q} + 33'd1;
	assign fire     = tick && (wait_inc == period);

	// Hold scale and wait count; restart on a scale write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= '0;
			wait_q  <= '0;
		end else if (wr) begin
			scale_q <= merge32(scale_q, mask, value);
			wait_q  <= '0;
		end else if (tick) begin
			wait_q <= fire ? 33'd0 : wait_inc;
		end
	end

endmodule

`default_nettype wire

>>> hdl/dpt_timer_lane.sv
// ----------------------------------------------------------------------------
// dpt_timer_lane: one target-compare timer
// Holds value, control, target and shift; compares the shifted value with
// the target on each timer prescaler fire and serves masked writes.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_timer_lane (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dpt_pkg::lane_ctl_t ctl,
	output      dpt_pkg::lane_stat_t stat
);
	import dpt_pkg::*;

	logic [63:0] value_q;
	logic [31:0] control_q;
	logic [31:0] target_q;
	logic [3:0]  shift_q;

	logic [63:0] seen;
	logic        enabled;
	logic        match;
	logic [31:0] ctrl_m;
	logic [31:0] view_m;
	logic [3:0]  new_shift;
	logic [63:0] base;

	// Shifted view and target compare
	assign seen    = value_q >> shift_q;
	assign enabled = control_q[CTRL_ENABLE_BIT];
	assign match   = (seen == {32'b0, target_q});

	// Merged write values
	assign ctrl_m    = merge32(control_q, ctl.mask, ctl.value);
	assign view_m    = merge32(seen[31:0], ctl.mask, ctl.value);
	assign new_shift = {1'b0, ctrl_m[SHIFT_LSB +: SHIFT_WIDTH]} + 4'd1;
	assign base      = ctrl_m[CTRL_ENABLE_BIT] ? value_q : 64'd0;

	assign stat.control = control_q;
	assign stat.view    = seen[31:0];
	assign stat.irq     = ctl.tick && enabled && match;

	// Update timer state for ticks and register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q   <= '0;
			control_q <= '0;
			target_q  <= '0;
			shift_q   <= '0;
		end else begin
			if (ctl.tick && enabled) begin
				value_q <= match ? 64'd0 : value_q + 64'd1;
			end
			if (ctl.wr_control) begin
				control_q <= ctrl_m;
				if (new_shift != shift_q) begin
					value_q <= (base >> shift_q) << new_shift;
					shift_q <= new_shift;
				end else begin
					value_q <= base;
				end
			end
			if (ctl.wr_value) begin
				value_q <= {32'b0, view_m} << shift_q;
			end
			if (ctl.wr_target) begin
				target_q <= merge32(target_q, ctl.mask, ctl.value);
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/dpt_checker.sv
// ----------------------------------------------------------------------------
// dpt_checker: port-level checks for the timer block
// Watches the command and result channels of the top level and is bound
// to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          cmd_valid,
	input wire logic          cmd_stall,
	input wire dpt_pkg::cmd_t cmd,
	input wire logic          res_valid,
	input wire logic          res_stall,
	input wire dpt_pkg::res_t res
);
	import dpt_pkg::*;

	// A stalled result transaction stays
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result dropped or changed while stalled");

	// Command stall only behind a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> res_valid && res_stall)
		else $error("command stalled without downstream backpressure");

	// An accepted transaction reaches the result port when not held back
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) ##1 !res_stall |=> res_valid)
		else $error("accepted command produced no result");

	// A result carries read data or IRQ bits, never both
	a_res_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.irq == '0) || (res.read_data == '0))
		else $error("result has both read data and IRQ bits");

endmodule

bind dual_prescaled_timer_with_counter dpt_checker u_dpt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_stall(cmd_stall),
	.cmd      (cmd),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res      (res)
);

`default_nettype wire
